// ===== src/sse_pkg.sv =====
// Package for the sparse set engine: sizes, opcodes and memory entry layout.
// Used by sparse_set_engine; depends on nothing else.
package sse_pkg;

  localparam int KEY_SPACE = 1024;
  localparam int KEY_W     = $clog2(KEY_SPACE);
  localparam int CNT_W     = $clog2(KEY_SPACE + 1);
  localparam int DATA_W    = 32;
  localparam int OP_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SET    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] pos;
  } slot_t;

endpackage

// ===== src/sparse_set_engine.sv =====
// Sparse set engine top level: slot, value and owner memories and their sequencer.
// Depends on sse_pkg.
// out_valid is set from S_OUT, reached through S_SLOT alone for set and for requests
// that change nothing, and through S_SLOT and then S_READ or S_REM2 for get and remove
// of a held key; S_OUT waits while an earlier result is still held by out_stall.
// One request is worked at a time; the next is accepted once the result is registered,
// so no new request is taken while one is in flight. After reset the slot memory is
// cleared entry by entry, with in_stall high, and the entry count starts at zero.
module sparse_set_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [sse_pkg::OP_W-1:0]  opcode,
  input  logic [sse_pkg::KEY_W-1:0] key,
  input  logic [sse_pkg::DATA_W-1:0] new_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      present,
  output logic [sse_pkg::DATA_W-1:0] read_value,
  output logic [sse_pkg::CNT_W-1:0] entry_count
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT,
    S_READ,
    S_REM2,
    S_OUT
  } state_t;

  state_t                     state;
  logic [sse_pkg::KEY_W-1:0]  clr_idx;
  logic [sse_pkg::CNT_W-1:0]  count;
  sse_pkg::opcode_t           op_q;
  logic [sse_pkg::KEY_W-1:0]  key_q;
  logic [sse_pkg::DATA_W-1:0] value_q;
  logic                       res_present;
  logic [sse_pkg::DATA_W-1:0] res_value;

  sse_pkg::slot_t             slot_mem [sse_pkg::KEY_SPACE];
  logic [sse_pkg::DATA_W-1:0] value_mem [sse_pkg::KEY_SPACE];
  logic [sse_pkg::KEY_W-1:0]  owner_mem [sse_pkg::KEY_SPACE];

  sse_pkg::slot_t             slot_rd;
  logic [sse_pkg::DATA_W-1:0] value_rd;
  logic [sse_pkg::KEY_W-1:0]  owner_rd;

  logic                       slot_we;
  logic [sse_pkg::KEY_W-1:0]  slot_wa;
  sse_pkg::slot_t             slot_wd;
  logic                       value_we;
  logic [sse_pkg::KEY_W-1:0]  value_wa;
  logic [sse_pkg::DATA_W-1:0] value_wd;
  logic [sse_pkg::KEY_W-1:0]  value_ra;
  logic                       owner_we;
  logic [sse_pkg::KEY_W-1:0]  owner_wa;
  logic [sse_pkg::KEY_W-1:0]  owner_wd;

  logic                       accept;
  logic                       held;
  logic [sse_pkg::KEY_W-1:0]  last_idx;
  logic [sse_pkg::KEY_W-1:0]  count_idx;
  logic                       full;
  logic                       do_append;
  logic                       do_remove;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign held      = slot_rd.valid;
  assign last_idx  = sse_pkg::KEY_W'(count - sse_pkg::CNT_W'(1));
  assign count_idx = count[sse_pkg::KEY_W-1:0];
  assign full      = (count == sse_pkg::CNT_W'(sse_pkg::KEY_SPACE));
  assign do_append = (state == S_SLOT) && (op_q == sse_pkg::OP_SET) && !held && !full;
  assign do_remove = (state == S_SLOT) && (op_q == sse_pkg::OP_REMOVE) && held;
  assign value_ra  = (state == S_SLOT) ? slot_rd.pos : last_idx;

  always_comb begin
    slot_we  = 1'b0;
    slot_wa  = key_q;
    slot_wd  = '0;
    value_we = 1'b0;
    value_wa = slot_rd.pos;
    value_wd = value_q;
    owner_we = 1'b0;
    owner_wa = slot_rd.pos;
    owner_wd = key_q;
    case (state)
      S_CLEAR: begin
        slot_we = 1'b1;
        slot_wa = clr_idx;
      end
      S_SLOT: begin
        if (op_q == sse_pkg::OP_SET && held) begin
          value_we = 1'b1;
        end else if (do_append) begin
          value_we      = 1'b1;
          value_wa      = count_idx;
          owner_we      = 1'b1;
          owner_wa      = count_idx;
          slot_we       = 1'b1;
          slot_wd.valid = 1'b1;
          slot_wd.pos   = count_idx;
        end else if (do_remove) begin
          value_we      = 1'b1;
          value_wd      = value_rd;
          owner_we      = 1'b1;
          owner_wd      = owner_rd;
          slot_we       = 1'b1;
          slot_wa       = owner_rd;
          slot_wd.valid = 1'b1;
          slot_wd.pos   = slot_rd.pos;
        end
      end
      S_REM2: begin
        slot_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot_rd <= slot_mem[key];
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
  end

  always_ff @(posedge clk) begin
    value_rd <= value_mem[value_ra];
    if (value_we) begin
      value_mem[value_wa] <= value_wd;
    end
  end

  always_ff @(posedge clk) begin
    owner_rd <= owner_mem[last_idx];
    if (owner_we) begin
      owner_mem[owner_wa] <= owner_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      count       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + sse_pkg::KEY_W'(1);
          if (clr_idx == sse_pkg::KEY_W'(sse_pkg::KEY_SPACE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q    <= sse_pkg::opcode_t'(opcode);
            key_q   <= key;
            value_q <= new_value;
            state   <= S_SLOT;
          end
        end
        S_SLOT: begin
          res_present <= held && (op_q != sse_pkg::OP_NONE);
          res_value   <= '0;
          if (do_append) begin
            count <= count + sse_pkg::CNT_W'(1);
          end
          if (do_remove) begin
            count <= count - sse_pkg::CNT_W'(1);
            state <= S_REM2;
          end else if (op_q == sse_pkg::OP_GET && held) begin
            state <= S_READ;
          end else begin
            state <= S_OUT;
          end
        end
        S_READ: begin
          res_value <= value_rd;
          state     <= S_OUT;
        end
        S_REM2: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            present     <= res_present;
            read_value  <= res_value;
            entry_count <= count;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
